### rtl/base64_stream_decoder_macros.svh
// assertion macros for the base64 stream decoder
// included by base64_stream_decoder.sv; no other dependencies
`ifndef BASE64_STREAM_DECODER_MACROS_SVH
`define BASE64_STREAM_DECODER_MACROS_SVH
`ifndef NO_ASSERTIONS
// property holds at every clock edge out of reset
`define BSD_ASSERT_ALWAYS(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("base64 decoder: invariant violated");
// consequent holds in the cycle after the antecedent
`define BSD_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("base64 decoder: sequence violated");
`else
`define BSD_ASSERT_ALWAYS(lbl, clk, rstn, prop)
`define BSD_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

### rtl/bsd_pkg.sv
// types, character codes and the sextet lookup for the base64 stream decoder
// no dependencies
package bsd_pkg;

  typedef enum logic [1:0] {
    StOk      = 2'd0,
    StBadLen  = 2'd1,
    StBadChar = 2'd2,
    StOverCap = 2'd3
  } status_e;

  localparam logic [7:0] CharUpA   = 8'h41;
  localparam logic [7:0] CharUpZ   = 8'h5A;
  localparam logic [7:0] CharLoA   = 8'h61;
  localparam logic [7:0] CharLoZ   = 8'h7A;
  localparam logic [7:0] CharDig0  = 8'h30;
  localparam logic [7:0] CharDig9  = 8'h39;
  localparam logic [7:0] CharPlus  = 8'h2B;
  localparam logic [7:0] CharSlash = 8'h2F;
  localparam logic [7:0] CharPad   = 8'h3D;

  localparam logic [5:0] SextetPlus  = 6'd62;
  localparam logic [5:0] SextetSlash = 6'd63;

  localparam logic [15:0] CountSat = 16'hFFFF;

  // one result beat before packing
  typedef struct packed {
    logic        kind;
    logic [7:0]  data;
    status_e     status;
    logic [15:0] count;
    logic        last;
  } result_t;

  // bit 6 set for a character outside the alphabet
  function automatic logic [6:0] sextet_of(logic [7:0] c);
    logic [6:0] s;
    s = 7'h40;
    if (c >= CharUpA && c <= CharUpZ) begin
      s = {1'b0, 6'(c - CharUpA)};
    end else if (c >= CharLoA && c <= CharLoZ) begin
      s = {1'b0, 6'(c - CharLoA + 8'd26)};
    end else if (c >= CharDig0 && c <= CharDig9) begin
      s = {1'b0, 6'(c - CharDig0 + 8'd52)};
    end else if (c == CharPlus) begin
      s = {1'b0, SextetPlus};
    end else if (c == CharSlash) begin
      s = {1'b0, SextetSlash};
    end
    return s;
  endfunction

endpackage

### rtl/base64_stream_decoder.sv
// base64 stream decoder: one text character per beat in, decoded bytes and
// a final status beat out; uses bsd_pkg and base64_stream_decoder_macros.svh
//
// channel   dir  fields (lsb up)                             handshake
// s_axis    in   tdata: text_char[7:0]; tlast: end_of_text   tvalid/tready
// m_axis    out  tdata: data_byte, status, byte_count;       tvalid/tready
//                tuser: item_kind; tlast: last
// cfg       in   cfg_wdata_i: out_capacity                   cfg_we_i
//
// one character per cycle: lookup and bit splice go straight from the input
// beat into a four-entry result queue, so a result is queued in the cycle after
// its character. the final character may push two results; the input stalls
// whenever fewer than two queue entries are free. reset clears the text state
// and the queue at once; out_capacity resets to 65535.
`include "base64_stream_decoder_macros.svh"

module base64_stream_decoder
  import bsd_pkg::*;
#(
  parameter int unsigned MAX_TEXT_LEN = 65535
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // text_char[7:0]
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // data_byte[7:0], status[9:8], byte_count[25:10]
  output logic        m_axis_tuser,   // item_kind[0]
  output logic        m_axis_tlast,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i
);

  localparam int CntW = $clog2(64'(MAX_TEXT_LEN) + 64'd1);
  localparam int CmpW = (CntW > 16) ? CntW : 16;
  localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_TEXT_LEN);
  localparam int QDepth = 4;
  localparam int QPtrW = $clog2(QDepth);

  logic [1:0]      pos_q, pos_d;
  logic [11:0]     prev_q, prev_d;
  logic            stopped_q, stopped_d;
  logic            bad_q, bad_d;
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] tri_q, tri_d;     // 3 * floor(count / 4)
  logic [15:0]     bytes_q, bytes_d;
  logic [1:0]      eq_q, eq_d;
  logic [15:0]     cap_q;

  result_t          queue_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QPtrW:0]   fill_q, fill_d;

  logic            s_accept, m_accept;
  logic            is_eq, active, stop_now, dec, emit;
  logic [6:0]      sx;
  logic [7:0]      byte_val;
  logic [CntW-1:0] pred;
  status_e         status;
  logic [15:0]     status_cnt;
  result_t         data_res, stat_res;
  logic [1:0]      push_n;

  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign m_accept      = m_axis_tvalid && m_axis_tready;
  assign s_axis_tready = fill_q <= (QPtrW+1)'(QDepth - 2);
  assign m_axis_tvalid = fill_q != '0;

  always_comb begin
    is_eq    = s_axis_tdata == CharPad;
    active   = !stopped_q && !bad_q;
    stop_now = active && is_eq && pos_q >= 2'd2;
    sx       = sextet_of(s_axis_tdata);
    dec      = active && !stop_now && !sx[6];
    emit     = dec && pos_q != 2'd0;

    case (pos_q)
      2'd1:    byte_val = {prev_q[5:0], sx[5:4]};
      2'd2:    byte_val = {prev_q[3:0], sx[5:2]};
      2'd3:    byte_val = {prev_q[1:0], sx[5:0]};
      default: byte_val = 8'h00;
    endcase

    pos_d     = pos_q + 2'd1;
    eq_d      = {eq_q[0], is_eq};
    stopped_d = stopped_q || stop_now;
    bad_d     = bad_q || (active && !stop_now && sx[6]);
    prev_d    = dec ? {prev_q[5:0], sx[5:0]} : prev_q;
    bytes_d   = (emit && bytes_q != CountSat) ? bytes_q + 16'd1 : bytes_q;
    count_d   = count_q;
    tri_d     = tri_q;
    if (count_q < MaxCnt) begin
      count_d = count_q + CntW'(1);
      if (count_d[1:0] == 2'd0) begin
        tri_d = tri_q + CntW'(3);
      end
    end

    // size predicted from whole quartets less trailing padding
    pred       = tri_d - CntW'(eq_d[0]) - CntW'(eq_d[1]);
    status_cnt = '0;
    if (count_d[1:0] != 2'd0 || count_d >= MaxCnt) begin
      status = StBadLen;
    end else if (CmpW'(pred) > CmpW'(cap_q)) begin
      status = StOverCap;
    end else if (bad_d) begin
      status = StBadChar;
    end else begin
      status     = StOk;
      status_cnt = bytes_d;
    end

    data_res = '{kind: 1'b0, data: byte_val, status: StOk, count: '0, last: 1'b0};
    stat_res = '{kind: 1'b1, data: 8'h00, status: status, count: status_cnt, last: 1'b1};
    push_n   = s_accept ? 2'(emit) + 2'(s_axis_tlast) : 2'd0;
    fill_d   = fill_q + (QPtrW+1)'(push_n) - (QPtrW+1)'(m_accept);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      prev_q    <= '0;
      stopped_q <= 1'b0;
      bad_q     <= 1'b0;
      count_q   <= '0;
      tri_q     <= '0;
      bytes_q   <= '0;
      eq_q      <= '0;
    end else if (s_accept) begin
      if (s_axis_tlast) begin
        pos_q     <= '0;
        prev_q    <= '0;
        stopped_q <= 1'b0;
        bad_q     <= 1'b0;
        count_q   <= '0;
        tri_q     <= '0;
        bytes_q   <= '0;
        eq_q      <= '0;
      end else begin
        pos_q     <= pos_d;
        prev_q    <= prev_d;
        stopped_q <= stopped_d;
        bad_q     <= bad_d;
        count_q   <= count_d;
        tri_q     <= tri_d;
        bytes_q   <= bytes_d;
        eq_q      <= eq_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CountSat;
    end else if (cfg_we_i) begin
      cap_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + QPtrW'(push_n);
      rd_ptr_q <= rd_ptr_q + QPtrW'(m_accept);
      fill_q   <= fill_d;
    end
  end

  // data beat goes first, status beat behind it when both are pushed
  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      if (emit) begin
        queue_q[wr_ptr_q] <= data_res;
        if (s_axis_tlast) begin
          queue_q[wr_ptr_q + QPtrW'(1)] <= stat_res;
        end
      end else if (s_axis_tlast) begin
        queue_q[wr_ptr_q] <= stat_res;
      end
    end
  end

  assign m_axis_tdata = {6'd0, queue_q[rd_ptr_q].count, queue_q[rd_ptr_q].status,
                         queue_q[rd_ptr_q].data};
  assign m_axis_tuser = queue_q[rd_ptr_q].kind;
  assign m_axis_tlast = queue_q[rd_ptr_q].last;

  `BSD_ASSERT_ALWAYS(a_fill_bound, clk_i, rst_ni, fill_q <= (QPtrW+1)'(QDepth))
  `BSD_ASSERT_NEXT(a_clear_after_final, clk_i, rst_ni, s_accept && s_axis_tlast,
                   pos_q == '0 && count_q == '0 && bytes_q == '0)
  `BSD_ASSERT_NEXT(a_status_queued, clk_i, rst_ni, s_accept && s_axis_tlast, fill_q != '0)

endmodule
